// ----- hw/rtl/mpts_pkg.sv -----
package mpts_pkg;

    localparam int CHANNELS = 16;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(CHANNELS + 1);

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_MASK  = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  channel;
        logic [15:0] pulse_count;
        logic [7:0]  amplitude;
        logic [31:0] on_time_ms;
        logic [31:0] off_time_ms;
        logic [15:0] enable_mask;
    } cmd_t;

    // one channel's train entry as held in the state memory
    typedef struct packed {
        logic [7:0]  level;
        logic [15:0] pulses_left;
        logic [31:0] on_period;
        logic [31:0] off_period;
        logic        phase_on;
        logic [31:0] next_event;
    } chan_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        chan_entry_t      wr_data;
    } ram_req_t;

endpackage

// ----- hw/rtl/mpts_chan_ram.sv -----
module mpts_chan_ram (
    input  logic                   aclk,
    input  mpts_pkg::ram_req_t     req,
    output mpts_pkg::chan_entry_t  rd_data
);

    mpts_pkg::chan_entry_t mem [mpts_pkg::CHANNELS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- hw/rtl/mpts_engine.sv -----
module mpts_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mpts_pkg::cmd_t         cmd,
    output mpts_pkg::ram_req_t     ram_req,
    input  mpts_pkg::chan_entry_t  ram_rd_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [3:0]             out_channel,
    output logic [7:0]             duty,
    output logic                   last_write
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FILL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    localparam int IDX_W = mpts_pkg::IDX_W;
    localparam int CNT_W = mpts_pkg::CNT_W;

    state_t                         state_reg, state_next;
    logic [31:0]                    clock_reg, clock_next;
    logic [mpts_pkg::CHANNELS-1:0]  active_reg, active_next;
    logic [CNT_W-1:0]               rd_idx_reg, rd_idx_next;
    logic                           ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]               ev_idx_reg, ev_idx_next;
    logic [IDX_W-1:0]               fill_idx_reg, fill_idx_next;
    logic [7:0]                     op_amp_reg, op_amp_next;
    logic [15:0]                    op_mask_reg, op_mask_next;
    logic                           op_is_mask_reg, op_is_mask_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]               pend_ch_reg, pend_ch_next;
    logic [7:0]                     pend_duty_reg, pend_duty_next;
    logic                           out_valid_reg, out_valid_next;
    logic [3:0]                     out_ch_reg, out_ch_next;
    logic [7:0]                     out_duty_reg, out_duty_next;
    logic                           out_last_reg, out_last_next;

    logic                   accept;
    logic                   start_ok;
    logic                   out_free;
    logic [31:0]            due_diff;
    logic                   ev_hit;
    logic                   stall;
    logic                   fill_go;
    logic                   rd_go;
    logic [31:0]            mask_shift;
    logic                   new_valid;
    logic [IDX_W-1:0]       new_ch;
    logic [7:0]             new_duty;
    logic [15:0]            pulses_dec;
    mpts_pkg::chan_entry_t  ev_entry;

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign start_ok    = (cmd.kind == mpts_pkg::KIND_START) && (cmd.pulse_count != 16'd0)
                         && (32'(cmd.channel) < mpts_pkg::CHANNELS);
    assign out_free    = !out_valid_reg || m_tready;

    // wrapped compare: due when clock minus event time is not negative
    assign due_diff    = clock_reg - ram_rd_data.next_event;
    assign ev_hit      = (state_reg == ST_SCAN) && ev_valid_reg && active_reg[ev_idx_reg]
                         && !due_diff[31];
    assign stall       = ev_hit && pend_valid_reg && !out_free;
    assign fill_go     = (state_reg == ST_FILL) && !(pend_valid_reg && !out_free);
    assign rd_go       = (state_reg == ST_SCAN) && (32'(rd_idx_reg) < mpts_pkg::CHANNELS)
                         && !stall;
    assign mask_shift  = 32'(op_mask_reg) >> fill_idx_reg;
    assign pulses_dec  = ram_rd_data.pulses_left - 16'd1;

    always_comb begin
        ev_entry = ram_rd_data;
        if (ram_rd_data.phase_on) begin
            ev_entry.phase_on    = 1'b0;
            ev_entry.next_event  = clock_reg + ram_rd_data.off_period;
            ev_entry.pulses_left = pulses_dec;
        end else begin
            ev_entry.phase_on   = 1'b1;
            ev_entry.next_event = clock_reg + ram_rd_data.on_period;
        end
    end

    // one result source per cycle at most
    always_comb begin
        new_valid = 1'b0;
        new_ch    = '0;
        new_duty  = '0;
        priority if (accept && start_ok) begin
            new_valid = 1'b1;
            new_ch    = IDX_W'(cmd.channel);
            new_duty  = cmd.amplitude;
        end else if (ev_hit && !stall) begin
            new_valid = 1'b1;
            new_ch    = ev_idx_reg;
            new_duty  = ram_rd_data.phase_on ? 8'd0 : ram_rd_data.level;
        end else if (fill_go) begin
            new_valid = 1'b1;
            new_ch    = fill_idx_reg;
            new_duty  = (op_is_mask_reg && mask_shift[0]) ? op_amp_reg : 8'd0;
        end
    end

    always_comb begin
        ram_req         = '0;
        ram_req.rd_en   = rd_go;
        ram_req.rd_addr = IDX_W'(rd_idx_reg);
        if (accept && start_ok) begin
            ram_req.wr_en               = 1'b1;
            ram_req.wr_addr             = IDX_W'(cmd.channel);
            ram_req.wr_data.level       = cmd.amplitude;
            ram_req.wr_data.pulses_left = cmd.pulse_count;
            ram_req.wr_data.on_period   = cmd.on_time_ms;
            ram_req.wr_data.off_period  = cmd.off_time_ms;
            ram_req.wr_data.phase_on    = 1'b1;
            ram_req.wr_data.next_event  = clock_reg + cmd.on_time_ms;
        end else if (ev_hit && !stall) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ev_idx_reg;
            ram_req.wr_data = ev_entry;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clock_next      = clock_reg;
        active_next     = active_reg;
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        fill_idx_next   = fill_idx_reg;
        op_amp_next     = op_amp_reg;
        op_mask_next    = op_mask_reg;
        op_is_mask_next = op_is_mask_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd.kind)
                        mpts_pkg::KIND_TICK: begin
                            clock_next    = clock_reg + 32'd1;
                            rd_idx_next   = '0;
                            ev_valid_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        mpts_pkg::KIND_START: begin
                            if (start_ok) begin
                                active_next[IDX_W'(cmd.channel)] = 1'b1;
                                state_next = ST_FLUSH;
                            end
                        end
                        mpts_pkg::KIND_MASK, mpts_pkg::KIND_STOP: begin
                            active_next     = '0;
                            fill_idx_next   = '0;
                            op_amp_next     = cmd.amplitude;
                            op_mask_next    = cmd.enable_mask;
                            op_is_mask_next = (cmd.kind == mpts_pkg::KIND_MASK);
                            state_next      = ST_FILL;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                // reads run one entry ahead of the write-back; addresses never coincide
                if (!stall) begin
                    ev_valid_next = rd_go;
                    ev_idx_next   = IDX_W'(rd_idx_reg);
                    if (rd_go) begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
                if (ev_hit && !stall && ram_rd_data.phase_on && pulses_dec == 16'd0) begin
                    active_next[ev_idx_reg] = 1'b0;
                end
                if (!ev_valid_reg && !rd_go && !stall) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FILL: begin
                if (fill_go) begin
                    if (fill_idx_reg == IDX_W'(mpts_pkg::CHANNELS - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        fill_idx_next = fill_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // the newest write waits in a holding slot until the next one shows it was not the last
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        pend_duty_next  = pend_duty_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_ch_next     = out_ch_reg;
        out_duty_next   = out_duty_reg;
        out_last_next   = out_last_reg;
        if (new_valid) begin
            pend_valid_next = 1'b1;
            pend_ch_next    = new_ch;
            pend_duty_next  = new_duty;
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_ch_next    = 4'(pend_ch_reg);
                out_duty_next  = pend_duty_reg;
                out_last_next  = 1'b0;
            end
        end else if (state_reg == ST_FLUSH && pend_valid_reg && out_free) begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_ch_next     = 4'(pend_ch_reg);
            out_duty_next   = pend_duty_reg;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clock_reg      <= '0;
            active_reg     <= '0;
            rd_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            fill_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clock_reg      <= clock_next;
            active_reg     <= active_next;
            rd_idx_reg     <= rd_idx_next;
            ev_valid_reg   <= ev_valid_next;
            fill_idx_reg   <= fill_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_idx_reg     <= ev_idx_next;
        op_amp_reg     <= op_amp_next;
        op_mask_reg    <= op_mask_next;
        op_is_mask_reg <= op_is_mask_next;
        pend_ch_reg    <= pend_ch_next;
        pend_duty_reg  <= pend_duty_next;
        out_ch_reg     <= out_ch_next;
        out_duty_reg   <= out_duty_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign duty        = out_duty_reg;
    assign last_write  = out_last_reg;

endmodule

// ----- hw/rtl/multichannel_pulse_train_scheduler.sv -----
// Sixteen-channel pulse-train duty scheduler.
// Slave channel: one command beat, s_tuser holds the kind (tick, start train,
// set by mask, stop all), s_tdata holds the command fields. Master channel:
// one beat per duty write, channel and duty in m_tdata, m_tlast on the final
// write caused by a command. Writes come out in ascending channel order.
// Throughput: one command at a time. A tick scans every channel entry in the
// state memory, one read per cycle unless the output stalls, through its single
// read port, with the reads running one entry ahead of the write-back.
// Set-by-mask and stop-all emit CHANNELS writes. A rejected start gives no
// write and leaves the input open; a tick write waits in the holding slot
// until the next write or the end of the scan.
// When the receiver stalls, one finished write waits in the output register
// and one more in a holding slot; the scan then pauses on the current entry
// and resumes when m_tready returns.
// Reset clears the millisecond clock, all train-active bits and the output
// valid; entry memory contents are only used for active channels.
module multichannel_pulse_train_scheduler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel, pulse_count, amplitude, on_time_ms, off_time_ms, enable_mask, zero pad
    input  logic [mpts_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_channel, duty, zero pad
    output logic [mpts_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    mpts_pkg::cmd_t         cmd;
    mpts_pkg::ram_req_t     ram_req;
    mpts_pkg::chan_entry_t  ram_rd_data;
    logic [3:0]             out_channel;
    logic [7:0]             duty;

    always_comb begin
        cmd.kind        = mpts_pkg::kind_t'(s_tuser);
        cmd.channel     = s_tdata[3:0];
        cmd.pulse_count = s_tdata[19:4];
        cmd.amplitude   = s_tdata[27:20];
        cmd.on_time_ms  = s_tdata[59:28];
        cmd.off_time_ms = s_tdata[91:60];
        cmd.enable_mask = s_tdata[107:92];
    end

    mpts_chan_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    mpts_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cmd         (cmd),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_channel (out_channel),
        .duty        (duty),
        .last_write  (m_tlast)
    );

    assign m_tdata = {4'd0, duty, out_channel};

endmodule

// ----- hw/rtl/mpts_checker.sv -----
module mpts_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mpts_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [1:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mpts_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // reset leaves no result pending and the input open
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not quiet after reset");

    // ticks, mask and stop commands keep the block busy past the accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != mpts_pkg::KIND_START |=> !s_tready)
        else $error("command accepted back to back with a scan");

    // a start with zero pulses gives no beat and frees the input at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == mpts_pkg::KIND_START && s_tdata[19:4] == 16'd0
        && !m_tvalid |=> s_tready && !m_tvalid)
        else $error("rejected start produced activity");

endmodule

bind multichannel_pulse_train_scheduler mpts_checker u_mpts_checker (.*);

// ----- dv/multichannel_pulse_train_scheduler_tb.sv -----
module multichannel_pulse_train_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpts_pkg::*;

    typedef struct {
        logic [3:0] out_channel;
        logic [7:0] duty;
        logic       last_write;
    } duty_write_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = KIND_TICK;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    multichannel_pulse_train_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // command stream and expected duty writes
    cmd_t        cmd_queue[$];
    duty_write_t pending_writes[$];
    int          n_cmds       = 0;
    int          cmds_issued  = 0;
    int          cmds_taken   = 0;
    int          mismatches   = 0;
    int          tx_gap       = 0;
    int          rx_gap       = 0;
    logic        rx_hold_off  = 1'b0;

    // scheduler state mirror
    logic [31:0] now_ms;
    logic        train_on  [CHANNELS];
    logic [7:0]  level     [CHANNELS];
    logic [15:0] pulses    [CHANNELS];
    logic [31:0] on_len    [CHANNELS];
    logic [31:0] off_len   [CHANNELS];
    logic        phase_on  [CHANNELS];
    logic [31:0] next_ev   [CHANNELS];

    function automatic cmd_t make_cmd(kind_t k, logic [3:0] ch, logic [15:0] cnt,
                                      logic [7:0] amp, logic [31:0] on_ms,
                                      logic [31:0] off_ms, logic [15:0] mask);
        cmd_t c;
        c.kind        = k;
        c.channel     = ch;
        c.pulse_count = cnt;
        c.amplitude   = amp;
        c.on_time_ms  = on_ms;
        c.off_time_ms = off_ms;
        c.enable_mask = mask;
        return c;
    endfunction

    task automatic advance_schedule(input kind_t k, input logic [S_TDATA_W-1:0] d);
        logic [3:0]  ch;
        logic [15:0] cnt;
        logic [7:0]  amp;
        logic [31:0] on_ms;
        logic [31:0] off_ms;
        logic [15:0] mask;
        logic [31:0] age;
        duty_write_t batch[$];
        ch     = d[3:0];
        cnt    = d[19:4];
        amp    = d[27:20];
        on_ms  = d[59:28];
        off_ms = d[91:60];
        mask   = d[107:92];
        case (k)
            KIND_TICK: begin
                now_ms = now_ms + 32'd1;
                for (int i = 0; i < CHANNELS; i++) begin
                    age = now_ms - next_ev[i];
                    // due once the event time is not in the future, modulo wrap
                    if (train_on[i] && !age[31]) begin
                        if (phase_on[i]) begin
                            batch.push_back('{4'(i), 8'd0, 1'b0});
                            phase_on[i] = 1'b0;
                            next_ev[i]  = now_ms + off_len[i];
                            pulses[i]   = pulses[i] - 16'd1;
                            if (pulses[i] == 16'd0)
                                train_on[i] = 1'b0;
                        end else begin
                            batch.push_back('{4'(i), level[i], 1'b0});
                            phase_on[i] = 1'b1;
                            next_ev[i]  = now_ms + on_len[i];
                        end
                    end
                end
            end
            KIND_START: begin
                if (cnt != 16'd0) begin
                    train_on[ch] = 1'b1;
                    level[ch]    = amp;
                    pulses[ch]   = cnt;
                    on_len[ch]   = on_ms;
                    off_len[ch]  = off_ms;
                    phase_on[ch] = 1'b1;
                    next_ev[ch]  = now_ms + on_ms;
                    batch.push_back('{ch, amp, 1'b0});
                end
            end
            default: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    batch.push_back('{4'(i), (k == KIND_MASK && mask[i]) ? amp : 8'd0, 1'b0});
                    train_on[i] = 1'b0;
                end
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last_write = 1'b1;
        foreach (batch[j])
            pending_writes.push_back(batch[j]);
    endtask

    // command driver
    always @(negedge aclk) begin
        logic                 vld;
        logic [S_TDATA_W-1:0] dat;
        logic [1:0]           usr;
        int                   gap;
        int                   issued;
        cmd_t                 c;
        vld    = s_tvalid;
        dat    = s_tdata;
        usr    = s_tuser;
        gap    = tx_gap;
        issued = cmds_issued;
        if (aresetn && !(s_tvalid && cmds_taken < cmds_issued)) begin
            if (gap > 0) begin
                gap = gap - 1;
                vld = 1'b0;
            end else if (issued < n_cmds - 60 && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 11) - 1;
                vld = 1'b0;
            end else if (cmd_queue.size() > 0) begin
                c      = cmd_queue.pop_front();
                dat    = {4'b0, c.enable_mask, c.off_time_ms, c.on_time_ms,
                          c.amplitude, c.pulse_count, c.channel};
                usr    = c.kind;
                vld    = 1'b1;
                issued = issued + 1;
            end else begin
                vld = 1'b0;
            end
        end
        s_tvalid    <= vld;
        s_tdata     <= dat;
        s_tuser     <= usr;
        tx_gap      <= gap;
        cmds_issued <= issued;
    end

    // duty write receiver
    always @(negedge aclk) begin
        logic rdy;
        int   gap;
        gap = rx_gap;
        if (rx_hold_off) begin
            rdy = 1'b0;
        end else if (gap > 0) begin
            gap = gap - 1;
            rdy = 1'b0;
        end else if (cmds_issued < n_cmds - 60 && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_tready <= rdy;
        rx_gap   <= gap;
    end

    // long receiver stall so the block backs up into its input
    initial begin
        wait (cmds_taken >= 60);
        @(negedge aclk);
        rx_hold_off <= 1'b1;
        repeat (400) @(negedge aclk);
        rx_hold_off <= 1'b0;
    end

    // monitor: check write beats, then predict from accepted command beats
    always @(posedge aclk) begin
        duty_write_t w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_writes.size() == 0) begin
                    $error("unexpected duty write: out_channel %0d duty %0d last_write %0d",
                           m_tdata[3:0], m_tdata[11:4], m_tlast);
                    mismatches++;
                end else begin
                    w = pending_writes.pop_front();
                    if (m_tdata[3:0] !== w.out_channel) begin
                        $error("out_channel: expected %0d, actual %0d",
                               w.out_channel, m_tdata[3:0]);
                        mismatches++;
                    end
                    if (m_tdata[11:4] !== w.duty) begin
                        $error("duty: expected %0d, actual %0d", w.duty, m_tdata[11:4]);
                        mismatches++;
                    end
                    if (m_tlast !== w.last_write) begin
                        $error("last_write: expected %0d, actual %0d", w.last_write, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_schedule(kind_t'(s_tuser), s_tdata);
                cmds_taken <= cmds_taken + 1;
            end
        end
    end

    initial begin : stimulus
        int          r;
        logic [15:0] cnt;
        logic [31:0] on_ms;
        logic [31:0] off_ms;
        kind_t       k;

        now_ms = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            train_on[i] = 1'b0;
            level[i]    = '0;
            pulses[i]   = '0;
            on_len[i]   = '0;
            off_len[i]  = '0;
            phase_on[i] = 1'b0;
            next_ev[i]  = '0;
        end

        // directed part
        cmd_queue.push_back(make_cmd(KIND_STOP,  4'd0,  16'd0,     8'd0,   32'd0, 32'd0, 16'd0));
        cmd_queue.push_back(make_cmd(KIND_MASK,  4'd0,  16'd0,     8'hff,  32'd0, 32'd0, 16'hffff));
        cmd_queue.push_back(make_cmd(KIND_MASK,  4'd0,  16'd0,     8'haa,  32'd0, 32'd0, 16'h0000));
        cmd_queue.push_back(make_cmd(KIND_MASK,  4'd5,  16'd9,     8'h5a,  32'd3, 32'd4, 16'ha5c3));
        // zero pulse count is rejected
        cmd_queue.push_back(make_cmd(KIND_START, 4'd0,  16'd0,     8'h11,  32'd1, 32'd1, 16'd0));
        cmd_queue.push_back(make_cmd(KIND_START, 4'd0,  16'd2,     8'hff,  32'd1, 32'd0, 16'd0));
        cmd_queue.push_back(make_cmd(KIND_START, 4'd15, 16'hffff,  8'h80,  32'd0,
                                     32'hffff_ffff, 16'hffff));
        // on time wraps to one behind the clock: due on the next tick
        cmd_queue.push_back(make_cmd(KIND_START, 4'd7,  16'd1,     8'd1,   32'hffff_ffff,
                                     32'd2, 16'd0));
        // half the clock range ahead: never due here
        cmd_queue.push_back(make_cmd(KIND_START, 4'd3,  16'd3,     8'h44,  32'h8000_0000,
                                     32'd0, 16'd0));
        // restart of an active channel overwrites its train
        cmd_queue.push_back(make_cmd(KIND_START, 4'd3,  16'd1,     8'h33,  32'd2, 32'd1, 16'd0));
        repeat (8)
            cmd_queue.push_back(make_cmd(KIND_TICK, 4'd0, 16'd0, 8'd0, 32'd0, 32'd0, 16'd0));
        cmd_queue.push_back(make_cmd(KIND_STOP,  4'd15, 16'hffff,  8'hff,  32'hffff_ffff,
                                     32'hffff_ffff, 16'hffff));
        // nothing active: tick gives no writes
        cmd_queue.push_back(make_cmd(KIND_TICK,  4'd15, 16'hffff,  8'hff,  32'hffff_ffff,
                                     32'hffff_ffff, 16'hffff));
        cmd_queue.push_back(make_cmd(KIND_START, 4'd9,  16'd1,     8'h7e,  32'd0, 32'd0, 16'd0));
        cmd_queue.push_back(make_cmd(KIND_TICK,  4'd0,  16'd0,     8'd0,   32'd0, 32'd0, 16'd0));
        cmd_queue.push_back(make_cmd(KIND_TICK,  4'd0,  16'd0,     8'd0,   32'd0, 32'd0, 16'd0));
        cmd_queue.push_back(make_cmd(KIND_MASK,  4'd0,  16'd0,     8'h7f,  32'd0, 32'd0, 16'h8001));
        cmd_queue.push_back(make_cmd(KIND_TICK,  4'd0,  16'd0,     8'd0,   32'd0, 32'd0, 16'd0));

        // random part: mostly short trains and ticks, some long or wrapped times
        repeat (405) begin
            r = $urandom_range(0, 99);
            if (r < 55)      k = KIND_TICK;
            else if (r < 85) k = KIND_START;
            else if (r < 93) k = KIND_MASK;
            else             k = KIND_STOP;
            r = $urandom_range(0, 9);
            if (r < 8)       cnt = 16'($urandom_range(1, 4));
            else if (r < 9)  cnt = 16'($urandom);
            else             cnt = 16'd0;
            on_ms  = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 6));
            off_ms = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 6));
            cmd_queue.push_back(make_cmd(k, 4'($urandom_range(0, 15)), cnt, 8'($urandom),
                                         on_ms, off_ms, 16'($urandom)));
        end
        n_cmds = cmd_queue.size();

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (cmds_taken < n_cmds || pending_writes.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && pending_writes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
